>>> sv/pdm_pkg.sv
package pdm_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int STEP_W = 5;
  localparam int ANG_W = 28;

  // controller commands to the datapath
  typedef struct packed {
    logic latch;      // capture input item, update counters
    logic mul_start;  // begin quaternion / distance products
    logic mul_step;   // one product step
    logic sq_start;   // begin both square roots
    logic sq_step;    // one root step
    logic cor_start;  // begin cordic
    logic cor_step;   // one cordic step
    logic finish;     // fold results into peaks, load output
  } pdm_cmd_t;

  // datapath status back to the controller
  typedef struct packed {
    logic mul_done;
    logic sq_done;
    logic cor_done;
    logic usable;
  } pdm_sts_t;

  // atan(2^-i) in units of 2^-20 degree
  function automatic logic [ANG_W-1:0] atan_lut(input logic [STEP_W-1:0] i);
    logic [ANG_W-1:0] v;
    case (i)
      5'd0: v = 28'd47185920;   5'd1: v = 28'd27855475;
      5'd2: v = 28'd14718068;   5'd3: v = 28'd7471121;
      5'd4: v = 28'd3750058;    5'd5: v = 28'd1876857;
      5'd6: v = 28'd938658;     5'd7: v = 28'd469357;
      5'd8: v = 28'd234682;     5'd9: v = 28'd117342;
      5'd10: v = 28'd58671;     5'd11: v = 28'd29335;
      5'd12: v = 28'd14668;     5'd13: v = 28'd7334;
      5'd14: v = 28'd3667;      5'd15: v = 28'd1833;
      5'd16: v = 28'd917;       5'd17: v = 28'd458;
      5'd18: v = 28'd229;       5'd19: v = 28'd115;
      5'd20: v = 28'd57;        5'd21: v = 28'd29;
      5'd22: v = 28'd14;        5'd23: v = 28'd7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> sv/pdm_ctrl.sv
module pdm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic              out_busy,
  input  logic              out_fire,
  input  pdm_pkg::pdm_sts_t sts,
  output pdm_pkg::pdm_cmd_t cmd,
  output logic              idle
);
  import pdm_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_SQ   = 3'd2;
  localparam logic [2:0] S_COR  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;
  localparam logic [2:0] S_WAIT = 3'd5;

  logic [2:0] state_r, state_nxt;

  // sequencing of one item through the shared units
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.latch = 1'b1;
          cmd.mul_start = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (sts.mul_done) begin
          cmd.sq_start = 1'b1;
          state_nxt = S_SQ;
        end else begin
          cmd.mul_step = 1'b1;
        end
      end
      S_SQ: begin
        if (sts.sq_done) begin
          cmd.cor_start = 1'b1;
          state_nxt = S_COR;
        end else begin
          cmd.sq_step = 1'b1;
        end
      end
      S_COR: begin
        if (sts.cor_done) begin
          state_nxt = S_FIN;
        end else begin
          cmd.cor_step = 1'b1;
        end
      end
      S_FIN: begin
        if (!out_busy || out_fire) begin
          cmd.finish = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_WAIT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign idle = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> sv/pdm_dpath.sv
module pdm_dpath #(
  parameter int POS_WIDTH = 24,
  parameter int QUAT_FRAC_BITS = 14,
  parameter int COUNT_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pdm_pkg::pdm_cmd_t cmd,
  output pdm_pkg::pdm_sts_t sts,
  input  logic              present,
  input  logic              pose_valid,
  input  logic [POS_WIDTH-1:0] px,
  input  logic [POS_WIDTH-1:0] py,
  input  logic [POS_WIDTH-1:0] pz,
  input  logic [15:0]       qw,
  input  logic [15:0]       qx,
  input  logic [15:0]       qy,
  input  logic [15:0]       qz,
  output logic              o_usable,
  output logic [24:0]       o_move,
  output logic [17:0]       o_turn,
  output logic [31:0]       o_frames,
  output logic [31:0]       o_good,
  output logic [31:0]       o_spells,
  output logic [31:0]       o_longest,
  output logic [24:0]       o_peak_move,
  output logic [17:0]       o_peak_turn,
  output logic [23:0]       o_spx,
  output logic [23:0]       o_spy,
  output logic [23:0]       o_spz
);
  import pdm_pkg::*;

  localparam int CW = COUNT_WIDTH;
  localparam logic [CW-1:0] CMAX = {CW{1'b1}};
  localparam int DW = POS_WIDTH + 1;      // position difference
  localparam int SW = 2 * 26 + 2;         // distance square sum (differences < 2^25)
  localparam int QW = 36;                 // relative quaternion part
  localparam int VW = 70;                 // vector square sum
  localparam int RW = 35;                 // vector norm
  localparam int XW = 40;                 // cordic x/y

  // saturate a count to the 32-bit report width
  function automatic logic [31:0] rep32(input logic [CW-1:0] c);
    logic [63:0] e;
    e = 64'(c);
    return (e > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : e[31:0];
  endfunction

  function automatic logic [CW-1:0] sinc(input logic [CW-1:0] c);
    return (c == CMAX) ? c : c + 1'b1;
  endfunction

  // persistent state
  logic                        have_ref_r;
  logic signed [POS_WIDTH-1:0] ref_p_r [3];
  logic signed [15:0]          ref_q_r [4];
  logic signed [POS_WIDTH-1:0] min_p_r [3];
  logic signed [POS_WIDTH-1:0] max_p_r [3];
  logic [CW-1:0] frames_r, good_r, spells_r, run_r, longest_r;
  logic [24:0]   peak_move_r;
  logic [17:0]   peak_turn_r;

  // item registers
  logic                        usable_r;
  logic signed [POS_WIDTH-1:0] p_r [3];
  logic signed [15:0]          q_r [4];

  logic usable_in;
  assign usable_in = present & pose_valid;

  logic signed [POS_WIDTH-1:0] pin [3];
  logic signed [15:0] qin [4];
  assign pin[0] = px; assign pin[1] = py; assign pin[2] = pz;
  assign qin[0] = qw; assign qin[1] = qx; assign qin[2] = qy; assign qin[3] = qz;

  // counters, reference, extrema on capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_ref_r <= 1'b0;
      frames_r <= '0; good_r <= '0; spells_r <= '0; run_r <= '0; longest_r <= '0;
      for (int i = 0; i < 3; i++) begin
        ref_p_r[i] <= '0; min_p_r[i] <= '0; max_p_r[i] <= '0;
      end
      ref_q_r[0] <= 16'(1 << QUAT_FRAC_BITS);
      ref_q_r[1] <= '0; ref_q_r[2] <= '0; ref_q_r[3] <= '0;
      usable_r <= 1'b0;
    end else if (cmd.latch) begin
      usable_r <= usable_in;
      frames_r <= sinc(frames_r);
      if (!usable_in) begin
        if (run_r == '0) spells_r <= sinc(spells_r);
        run_r <= sinc(run_r);
        if (sinc(run_r) > longest_r) longest_r <= sinc(run_r);
      end else begin
        run_r <= '0;
        good_r <= sinc(good_r);
        if (!have_ref_r) begin
          have_ref_r <= 1'b1;
          for (int i = 0; i < 3; i++) begin
            ref_p_r[i] <= pin[i]; min_p_r[i] <= pin[i]; max_p_r[i] <= pin[i];
          end
          for (int i = 0; i < 4; i++) ref_q_r[i] <= qin[i];
        end else begin
          for (int i = 0; i < 3; i++) begin
            if (pin[i] < min_p_r[i]) min_p_r[i] <= pin[i];
            if (pin[i] > max_p_r[i]) max_p_r[i] <= pin[i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      for (int i = 0; i < 3; i++) p_r[i] <= pin[i];
      for (int i = 0; i < 4; i++) q_r[i] <= qin[i];
    end
  end

  // product sequencer: one multiplier-sized product per step
  logic [3:0] mstep_r;
  logic signed [QW-1:0] rw_r, rx_r, ry_r, rz_r;
  logic [SW-1:0] dsum_r;
  logic far_r;
  logic [VW-1:0] vsum_r;
  logic [33:0] wn_r;

  logic signed [DW-1:0] dif [3];
  logic [DW-1:0] adif [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dif[i] = DW'(p_r[i]) - DW'(ref_p_r[i]);
      adif[i] = dif[i][DW-1] ? DW'(-dif[i]) : DW'(dif[i]);
    end
  end

  logic signed [31:0] prod;
  logic signed [15:0] ma, mb;
  logic [DW-1:0] dsel;
  always_comb begin
    ma = '0; mb = '0;
    case (mstep_r)
      4'd0: begin ma = ref_q_r[0]; mb = q_r[0]; end
      4'd1: begin ma = ref_q_r[1]; mb = q_r[1]; end
      4'd2: begin ma = ref_q_r[2]; mb = q_r[2]; end
      4'd3: begin ma = ref_q_r[3]; mb = q_r[3]; end
      4'd4: begin ma = ref_q_r[0]; mb = q_r[1]; end
      4'd5: begin ma = q_r[0];     mb = ref_q_r[1]; end
      4'd6: begin ma = ref_q_r[2]; mb = q_r[3]; end
      4'd7: begin ma = ref_q_r[3]; mb = q_r[2]; end
      4'd8: begin ma = ref_q_r[0]; mb = q_r[2]; end
      4'd9: begin ma = q_r[0];     mb = ref_q_r[2]; end
      4'd10: begin ma = ref_q_r[3]; mb = q_r[1]; end
      4'd11: begin ma = ref_q_r[1]; mb = q_r[3]; end
      4'd12: begin ma = ref_q_r[0]; mb = q_r[3]; end
      4'd13: begin ma = q_r[0];     mb = ref_q_r[3]; end
      4'd14: begin ma = ref_q_r[1]; mb = q_r[2]; end
      4'd15: begin ma = ref_q_r[2]; mb = q_r[1]; end
      default: ;
    endcase
    prod = ma * mb;
  end

  // distance squares use a second multiplier, one axis per step
  logic [2*DW-1:0] dsq;
  always_comb begin
    case (mstep_r[1:0])
      2'd0: dsel = adif[0];
      2'd1: dsel = adif[1];
      default: dsel = adif[2];
    endcase
    dsq = dsel * dsel;
  end

  // vector squares after the parts are formed, steps 1..3 take x, y, z
  logic [4:0] vstep_r;
  logic [34:0] vabs;
  logic [69:0] vsq;
  always_comb begin
    case (vstep_r[1:0])
      2'd1: vabs = rx_r[QW-1] ? 35'(-rx_r >>> 1) : 35'(rx_r >>> 1);
      2'd2: vabs = ry_r[QW-1] ? 35'(-ry_r >>> 1) : 35'(ry_r >>> 1);
      default: vabs = rz_r[QW-1] ? 35'(-rz_r >>> 1) : 35'(rz_r >>> 1);
    endcase
    vsq = vabs * vabs;
  end

  logic mul_busy_r, mul_done_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_busy_r <= 1'b0; mul_done_r <= 1'b0;
      mstep_r <= '0; vstep_r <= '0;
    end else if (cmd.mul_start) begin
      mul_busy_r <= 1'b1; mul_done_r <= 1'b0;
      mstep_r <= '0; vstep_r <= '0;
    end else if (cmd.mul_step && !mul_done_r) begin
      if (mstep_r != 4'd15) mstep_r <= mstep_r + 1'b1;
      else vstep_r <= vstep_r + 1'b1;
      if (vstep_r == 5'd3) begin
        mul_done_r <= 1'b1; mul_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      rw_r <= '0; rx_r <= '0; ry_r <= '0; rz_r <= '0;
      dsum_r <= '0; far_r <= 1'b0; vsum_r <= '0;
    end else if (cmd.mul_step && !mul_done_r) begin
      if (vstep_r == 5'd0) begin
        case (mstep_r)
          4'd0, 4'd1, 4'd2, 4'd3: rw_r <= rw_r + QW'(prod);
          4'd4: rx_r <= rx_r + QW'(prod);
          4'd5, 4'd6: rx_r <= rx_r - QW'(prod);
          4'd7: rx_r <= rx_r + QW'(prod);
          4'd8: ry_r <= ry_r + QW'(prod);
          4'd9, 4'd10: ry_r <= ry_r - QW'(prod);
          4'd11: ry_r <= ry_r + QW'(prod);
          4'd12: rz_r <= rz_r + QW'(prod);
          4'd13, 4'd14: rz_r <= rz_r - QW'(prod);
          4'd15: rz_r <= rz_r + QW'(prod);
          default: ;
        endcase
        if (mstep_r < 4'd3) begin
          if (dsel >= DW'(1 << 25) && DW > 25) far_r <= 1'b1;
          dsum_r <= dsum_r + SW'(dsq);
        end
      end
      if (mstep_r == 4'd15 && vstep_r != 5'd0 && vstep_r <= 5'd3) begin
        vsum_r <= vsum_r + VW'(vsq);
      end
    end
  end

  // restoring square roots, one result bit per step, both in the same pass
  logic [SW-1:0] dn_r, dr_r, dbit_r;
  logic [VW-1:0] vn_r, vr_r, vbit_r;
  logic sq_done_r;
  always_ff @(posedge clk) begin
    if (cmd.sq_start) begin
      dn_r <= dsum_r; dr_r <= '0; dbit_r <= SW'(1) << (SW - 2);
      vn_r <= vsum_r; vr_r <= '0; vbit_r <= VW'(1) << (VW - 2);
      sq_done_r <= 1'b0;
      wn_r <= rw_r[QW-1] ? 34'((-rw_r) >>> 1) : 34'(rw_r >>> 1);
    end else if (cmd.sq_step && !sq_done_r) begin
      if (dbit_r != '0) begin
        if (dn_r >= dr_r + dbit_r) begin
          dn_r <= dn_r - (dr_r + dbit_r);
          dr_r <= (dr_r >> 1) + dbit_r;
        end else begin
          dr_r <= dr_r >> 1;
        end
        dbit_r <= dbit_r >> 2;
      end
      if (vbit_r != '0) begin
        if (vn_r >= vr_r + vbit_r) begin
          vn_r <= vn_r - (vr_r + vbit_r);
          vr_r <= (vr_r >> 1) + vbit_r;
        end else begin
          vr_r <= vr_r >> 1;
        end
        vbit_r <= vbit_r >> 2;
      end
      if ((vbit_r >> 2) == '0 && (dbit_r >> 2) == '0) sq_done_r <= 1'b1;
    end
  end

  // cordic vectoring, one rotation per step
  logic signed [XW-1:0] cx_r, cy_r;
  logic signed [ANG_W:0] cz_r;
  logic [STEP_W-1:0] cstep_r;
  logic cor_done_r;
  always_ff @(posedge clk) begin
    if (cmd.cor_start) begin
      cx_r <= XW'(wn_r); cy_r <= XW'(vr_r[RW-1:0]);
      cz_r <= '0; cstep_r <= '0; cor_done_r <= 1'b0;
    end else if (cmd.cor_step && !cor_done_r) begin
      if (cy_r > 0) begin
        cx_r <= cx_r + (cy_r >>> cstep_r);
        cy_r <= cy_r - (cx_r >>> cstep_r);
        cz_r <= cz_r + $signed({1'b0, atan_lut(cstep_r)});
      end else begin
        cx_r <= cx_r - (cy_r >>> cstep_r);
        cy_r <= cy_r + (cx_r >>> cstep_r);
        cz_r <= cz_r - $signed({1'b0, atan_lut(cstep_r)});
      end
      cstep_r <= cstep_r + 1'b1;
      if (cstep_r == STEP_W'(CORDIC_STEPS - 1)) cor_done_r <= 1'b1;
    end
  end

  // final rounding and clamps
  logic [24:0] move_v;
  logic [17:0] turn_v;
  logic [ANG_W-1:0] zc;
  logic [ANG_W+11:0] md;
  always_comb begin
    if (far_r || dr_r + ((dn_r > dr_r) ? 1 : 0) > SW'(33554431)) move_v = 25'h1FF_FFFF;
    else move_v = 25'(dr_r + ((dn_r > dr_r) ? SW'(1) : SW'(0)));
    if (cz_r < 0) zc = '0;
    else if (cz_r > (ANG_W+1)'(90 * 1048576)) zc = ANG_W'(90 * 1048576);
    else zc = cz_r[ANG_W-1:0];
    md = ((ANG_W+12)'(zc) * 2000 + (1 << 19)) >> 20;
    if (vr_r == '0) turn_v = '0;
    else if (wn_r == '0) turn_v = 18'd180000;
    else if (md > 180000) turn_v = 18'd180000;
    else turn_v = md[17:0];
    if (!usable_r) begin
      move_v = '0; turn_v = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_move_r <= '0; peak_turn_r <= '0;
    end else if (cmd.finish) begin
      if (move_v > peak_move_r) peak_move_r <= move_v;
      if (turn_v > peak_turn_r) peak_turn_r <= turn_v;
    end
  end

  // output holding register
  function automatic logic [23:0] spr(input logic signed [POS_WIDTH-1:0] hi,
                                      input logic signed [POS_WIDTH-1:0] lo);
    logic signed [POS_WIDTH:0] s;
    s = (POS_WIDTH+1)'(hi) - (POS_WIDTH+1)'(lo);
    return (s > (POS_WIDTH+1)'(24'hFF_FFFF)) ? 24'hFF_FFFF : 24'(s);
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      o_usable <= usable_r;
      o_move <= move_v;
      o_turn <= turn_v;
      o_frames <= rep32(frames_r);
      o_good <= rep32(good_r);
      o_spells <= rep32(spells_r);
      o_longest <= rep32(longest_r);
      o_peak_move <= (move_v > peak_move_r) ? move_v : peak_move_r;
      o_peak_turn <= (turn_v > peak_turn_r) ? turn_v : peak_turn_r;
      o_spx <= spr(max_p_r[0], min_p_r[0]);
      o_spy <= spr(max_p_r[1], min_p_r[1]);
      o_spz <= spr(max_p_r[2], min_p_r[2]);
    end
  end

  assign sts.mul_done = mul_done_r & ~mul_busy_r;
  assign sts.sq_done = sq_done_r;
  assign sts.cor_done = cor_done_r;
  assign sts.usable = usable_r;

endmodule

>>> sv/pose_drift_monitor_core.sv
// from input transfer to result valid: 19 product steps, 35 root steps, 24 cordic
// steps, a handoff after each unit and a finish step at the end
// one pose at a time, taken only once the last is done, paced by the shared multiplier,
// the bit-serial square roots and the cordic loop; a held result stalls the finish
// reset: synchronous active-low rst_n clears counters, reference and peaks
module pose_drift_monitor_core #(
  parameter int POS_WIDTH = 24,
  parameter int QUAT_FRAC_BITS = 14,
  parameter int COUNT_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata: pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z
  input  logic [3*POS_WIDTH+63:0] in_tdata,
  // tuser: present, pose_valid
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // tdata: move_from_ref, turn_from_ref, frames_seen, good_frames, bad_spells,
  // longest_bad_run, peak_move, peak_turn, spread_x, spread_y, spread_z
  output logic [287:0] out_tdata,
  // tuser: usable
  output logic [0:0]   out_tuser
);
  import pdm_pkg::*;

  localparam int PW = POS_WIDTH;

  pdm_cmd_t cmd;
  pdm_sts_t sts;
  logic idle, out_valid_r, in_fire, out_fire;

  assign in_tready = idle;
  assign in_fire = in_tvalid & in_tready;
  assign out_fire = out_valid_r & out_tready;

  pdm_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .out_busy(out_valid_r), .out_fire, .sts, .cmd, .idle
  );

  logic o_usable;
  logic [24:0] o_move, o_peak_move;
  logic [17:0] o_turn, o_peak_turn;
  logic [31:0] o_frames, o_good, o_spells, o_longest;
  logic [23:0] o_spx, o_spy, o_spz;

  pdm_dpath #(.POS_WIDTH(POS_WIDTH), .QUAT_FRAC_BITS(QUAT_FRAC_BITS),
              .COUNT_WIDTH(COUNT_WIDTH)) u_dpath (
    .clk, .rst_n, .cmd, .sts,
    .present(in_tuser[0]), .pose_valid(in_tuser[1]),
    .px(in_tdata[PW-1:0]), .py(in_tdata[2*PW-1:PW]), .pz(in_tdata[3*PW-1:2*PW]),
    .qw(in_tdata[3*PW+15:3*PW]), .qx(in_tdata[3*PW+31:3*PW+16]),
    .qy(in_tdata[3*PW+47:3*PW+32]), .qz(in_tdata[3*PW+63:3*PW+48]),
    .o_usable, .o_move, .o_turn, .o_frames, .o_good, .o_spells, .o_longest,
    .o_peak_move, .o_peak_turn, .o_spx, .o_spy, .o_spz
  );

  // output valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser = o_usable;
  assign out_tdata = {2'd0, o_spz, o_spy, o_spx, o_peak_turn, o_peak_move,
                      o_longest, o_spells, o_good, o_frames, o_turn, o_move};

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.latch |=> !in_tready) else $error("accepted while busy");
  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || out_tready)) else $error("result overwritten");
  a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_tvalid) else $error("result lost");
`endif

endmodule
